>>> design/csl_pkg.sv
// csl_pkg: shared codes, character constants and classification helpers
// for the C subset lexer. No dependencies.
`timescale 1ns / 1ps

package csl_pkg;

    // Default lexeme buffer depth; the longest lexeme is one less
    localparam int MAX_LEXEME_DEF = 32;

    localparam int CH_W  = 8;
    localparam int CLS_W = 3;
    localparam int SUB_W = 2;
    localparam int LEN_W = 5;

    // Token classes
    localparam logic [CLS_W-1:0] CLS_KEYWORD = 3'd0;
    localparam logic [CLS_W-1:0] CLS_IDENT   = 3'd1;
    localparam logic [CLS_W-1:0] CLS_LITERAL = 3'd2;
    localparam logic [CLS_W-1:0] CLS_OPER    = 3'd3;
    localparam logic [CLS_W-1:0] CLS_DELIM   = 3'd4;
    localparam logic [CLS_W-1:0] CLS_ERROR   = 3'd5;

    // Subtypes
    localparam logic [SUB_W-1:0] SUB_NONE     = 2'd0;
    localparam logic [SUB_W-1:0] SUB_KW_INT   = 2'd0;
    localparam logic [SUB_W-1:0] SUB_KW_CHAR  = 2'd1;
    localparam logic [SUB_W-1:0] SUB_KW_CONT  = 2'd2;
    localparam logic [SUB_W-1:0] SUB_LIT_NUM  = 2'd0;
    localparam logic [SUB_W-1:0] SUB_LIT_STR  = 2'd1;
    localparam logic [SUB_W-1:0] SUB_OP_SLASH = 2'd0;
    localparam logic [SUB_W-1:0] SUB_OP_MINUS = 2'd1;
    localparam logic [SUB_W-1:0] SUB_OP_EQ    = 2'd2;
    localparam logic [SUB_W-1:0] SUB_DL_LPAR  = 2'd0;
    localparam logic [SUB_W-1:0] SUB_DL_RPAR  = 2'd1;
    localparam logic [SUB_W-1:0] SUB_DL_COMMA = 2'd2;
    localparam logic [SUB_W-1:0] SUB_DL_SEMI  = 2'd3;

    // Keyword selectors
    localparam logic [1:0] KW_INT  = 2'd0;
    localparam logic [1:0] KW_CHAR = 2'd1;
    localparam logic [1:0] KW_CONT = 2'd2;

    // Characters of interest
    localparam logic [CH_W-1:0] C_SEMI   = 8'h3B;
    localparam logic [CH_W-1:0] C_COMMA  = 8'h2C;
    localparam logic [CH_W-1:0] C_LPAR   = 8'h28;
    localparam logic [CH_W-1:0] C_RPAR   = 8'h29;
    localparam logic [CH_W-1:0] C_EQ     = 8'h3D;
    localparam logic [CH_W-1:0] C_MINUS  = 8'h2D;
    localparam logic [CH_W-1:0] C_SLASH  = 8'h2F;
    localparam logic [CH_W-1:0] C_DOT    = 8'h2E;
    localparam logic [CH_W-1:0] C_BSLASH = 8'h5C;
    localparam logic [CH_W-1:0] C_QUOTE  = 8'h22;
    localparam logic [CH_W-1:0] C_UNDER  = 8'h5F;
    localparam logic [CH_W-1:0] C_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] C_ZERO   = 8'h00;

    function automatic logic is_digit(input logic [CH_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [CH_W-1:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_wordch(input logic [CH_W-1:0] c);
        return is_alpha(c) || is_digit(c) || (c == C_UNDER);
    endfunction

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [CH_W-1:0] c);
        return (c == C_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_opch(input logic [CH_W-1:0] c);
        return (c == C_EQ) || (c == C_MINUS) || (c == C_SLASH);
    endfunction

    function automatic logic [SUB_W-1:0] op_sub(input logic [CH_W-1:0] c);
        logic [SUB_W-1:0] s;
        if (c == C_SLASH)
            s = SUB_OP_SLASH;
        else if (c == C_MINUS)
            s = SUB_OP_MINUS;
        else
            s = SUB_OP_EQ;
        return s;
    endfunction

    // Keyword spelling by position; zero past the end never matches a word char
    function automatic logic [CH_W-1:0] kw_char(input logic [1:0] kw, input logic [5:0] idx);
        logic [CH_W-1:0] r;
        r = C_ZERO;
        unique case (kw)
            KW_INT:
            begin
                case (idx)
                    6'd0: r = "i";
                    6'd1: r = "n";
                    6'd2: r = "t";
                    default: r = C_ZERO;
                endcase
            end
            KW_CHAR:
            begin
                case (idx)
                    6'd0: r = "c";
                    6'd1: r = "h";
                    6'd2: r = "a";
                    6'd3: r = "r";
                    default: r = C_ZERO;
                endcase
            end
            KW_CONT:
            begin
                case (idx)
                    6'd0: r = "c";
                    6'd1: r = "o";
                    6'd2: r = "n";
                    6'd3: r = "t";
                    6'd4: r = "i";
                    6'd5: r = "n";
                    6'd6: r = "u";
                    6'd7: r = "e";
                    default: r = C_ZERO;
                endcase
            end
            default: r = C_ZERO;
        endcase
        return r;
    endfunction

endpackage

>>> design/csl_ram.sv
// csl_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module csl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read; read data holds when re is low
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/c_subset_lexer.sv
// c_subset_lexer: streaming tokenizer for a small C subset.
// Uses csl_pkg and keeps the lexeme in one csl_ram instance.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, ch, end_of_text       | into block
//   out     | out_valid, out_stall, tok_class, tok_sub, | out of block
//           | lex_char, lex_len, last_char              |
//
// One input beat per cycle while a token builds and the output register is free.
// The beat that ends a token issues the first RAM read; its characters then
// leave one per cycle while out is not held.
// A character that ended a token is replayed from pend_reg once the token is out.
// Input is stalled while a token drains, on the replay cycle and while out is held.
// Reset (rst_n low, asynchronous) clears every state and output register; the lexeme RAM is not reset.
`timescale 1ns / 1ps

module c_subset_lexer
    import csl_pkg::*;
#(
    parameter int MAX_LEXEME = MAX_LEXEME_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [CH_W-1:0]  ch,
    input  logic             end_of_text,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [CLS_W-1:0] tok_class,
    output logic [SUB_W-1:0] tok_sub,
    output logic [CH_W-1:0]  lex_char,
    output logic [LEN_W-1:0] lex_len,
    output logic             last_char
);

    localparam int AW    = $clog2(MAX_LEXEME);
    localparam int CNT_W = $clog2(MAX_LEXEME + 1);

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_INT, M_DOT, M_FRAC, M_STR, M_ESC, M_OP, M_ERR
    } mode_t;

    typedef enum logic [1:0] {
        CTL_RUN, CTL_EMIT, CTL_START
    } ctl_t;

    // State registers
    mode_t             mode_reg, mode_next;
    ctl_t              ctl_reg, ctl_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              kwi_reg, kwi_next;
    logic              kwc_reg, kwc_next;
    logic              kwk_reg, kwk_next;
    logic [CH_W-1:0]   opf_reg, opf_next;
    logic [CH_W-1:0]   pend_reg, pend_next;
    logic              pend_v_reg, pend_v_next;
    logic [CLS_W-1:0]  em_cls_reg, em_cls_next;
    logic [SUB_W-1:0]  em_sub_reg, em_sub_next;
    logic [CNT_W-1:0]  em_cnt_reg, em_cnt_next;
    logic [AW-1:0]     em_idx_reg, em_idx_next;

    // Output register
    logic              out_v_reg, out_v_next;
    logic [CLS_W-1:0]  o_cls_reg, o_cls_next;
    logic [SUB_W-1:0]  o_sub_reg, o_sub_next;
    logic [CH_W-1:0]   o_ch_reg, o_ch_next;
    logic [LEN_W-1:0]  o_len_reg, o_len_next;
    logic              o_last_reg, o_last_next;

    // RAM ports
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CH_W-1:0]   wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [CH_W-1:0]   rd_data;

    // Step decode
    logic              out_free;
    logic              fire;
    logic [CH_W-1:0]   c;
    logic              eot;
    logic              app, err, start, emit_go, pend_set;
    logic [CNT_W-1:0]  cnt_inc;
    logic              em_last;

    csl_ram #(
        .WIDTH (CH_W),
        .DEPTH (MAX_LEXEME)
    ) u_lexeme_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign out_free = !out_v_reg || !out_stall;
    assign in_stall = (ctl_reg != CTL_RUN) || !out_free;

    // The deferred character that ended a token is replayed from pend_reg
    assign fire = (ctl_reg == CTL_RUN)   ? (in_valid && !in_stall) :
                  (ctl_reg == CTL_START) ? out_free : 1'b0;
    assign c    = (ctl_reg == CTL_START) ? pend_reg : ch;
    assign eot  = (ctl_reg == CTL_START) ? 1'b0 : end_of_text;

    assign cnt_inc = cnt_reg + CNT_W'(1);
    assign em_last = (CNT_W'(em_idx_reg) + CNT_W'(1)) == em_cnt_reg;

    always_comb
    begin
        mode_next   = mode_reg;
        ctl_next    = ctl_reg;
        cnt_next    = cnt_reg;
        kwi_next    = kwi_reg;
        kwc_next    = kwc_reg;
        kwk_next    = kwk_reg;
        opf_next    = opf_reg;
        pend_next   = pend_reg;
        pend_v_next = pend_v_reg;
        em_cls_next = em_cls_reg;
        em_sub_next = em_sub_reg;
        em_cnt_next = em_cnt_reg;
        em_idx_next = em_idx_reg;
        out_v_next  = out_v_reg && out_stall;
        o_cls_next  = o_cls_reg;
        o_sub_next  = o_sub_reg;
        o_ch_next   = o_ch_reg;
        o_len_next  = o_len_reg;
        o_last_next = o_last_reg;
        wr_en       = 1'b0;
        wr_addr     = cnt_reg[AW-1:0];
        wr_data     = c;
        rd_en       = 1'b0;
        rd_addr     = '0;
        app         = 1'b0;
        err         = 1'b0;
        start       = 1'b0;
        emit_go     = 1'b0;
        pend_set    = 1'b0;

        if (fire)
        begin
            // Per-mode decision for the current beat
            if (eot)
            begin
                unique case (mode_reg) inside
                    M_WORD:
                    begin
                        emit_go = 1'b1;
                    end
                    M_INT, M_FRAC:
                    begin
                        emit_go     = 1'b1;
                        em_cls_next = CLS_LITERAL;
                        em_sub_next = SUB_LIT_NUM;
                    end
                    M_DOT, M_STR, M_ESC:
                    begin
                        err = 1'b1;
                    end
                    M_OP:
                    begin
                        if (cnt_reg == CNT_W'(1))
                        begin
                            out_v_next  = 1'b1;
                            o_cls_next  = CLS_OPER;
                            o_sub_next  = op_sub(opf_reg);
                            o_ch_next   = opf_reg;
                            o_len_next  = LEN_W'(1);
                            o_last_next = 1'b1;
                        end
                        else
                            err = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else
            begin
                unique case (mode_reg)
                    M_IDLE:
                    begin
                        start = 1'b1;
                    end
                    M_WORD:
                    begin
                        if (is_wordch(c))
                            app = 1'b1;
                        else
                        begin
                            emit_go  = 1'b1;
                            pend_set = 1'b1;
                        end
                    end
                    M_INT:
                    begin
                        if (is_digit(c))
                            app = 1'b1;
                        else if (c == C_DOT)
                        begin
                            app       = 1'b1;
                            mode_next = M_DOT;
                        end
                        else
                        begin
                            emit_go     = 1'b1;
                            pend_set    = 1'b1;
                            em_cls_next = CLS_LITERAL;
                            em_sub_next = SUB_LIT_NUM;
                        end
                    end
                    M_DOT:
                    begin
                        if (is_digit(c))
                        begin
                            app       = 1'b1;
                            mode_next = M_FRAC;
                        end
                        else
                            err = 1'b1;
                    end
                    M_FRAC:
                    begin
                        if (is_digit(c))
                            app = 1'b1;
                        else
                        begin
                            emit_go     = 1'b1;
                            pend_set    = 1'b1;
                            em_cls_next = CLS_LITERAL;
                            em_sub_next = SUB_LIT_NUM;
                        end
                    end
                    M_STR:
                    begin
                        if (c == C_QUOTE)
                        begin
                            if (cnt_reg == '0)
                            begin
                                // empty string: one beat, no lexeme
                                out_v_next  = 1'b1;
                                o_cls_next  = CLS_LITERAL;
                                o_sub_next  = SUB_LIT_STR;
                                o_ch_next   = C_ZERO;
                                o_len_next  = '0;
                                o_last_next = 1'b1;
                                mode_next   = M_IDLE;
                            end
                            else
                            begin
                                emit_go     = 1'b1;
                                em_cls_next = CLS_LITERAL;
                                em_sub_next = SUB_LIT_STR;
                            end
                        end
                        else
                        begin
                            app = 1'b1;
                            if (c == C_BSLASH)
                                mode_next = M_ESC;
                        end
                    end
                    M_ESC:
                    begin
                        app       = 1'b1;
                        mode_next = M_STR;
                    end
                    M_OP:
                    begin
                        if (is_opch(c))
                            app = 1'b1;
                        else if (cnt_reg != CNT_W'(1))
                            err = 1'b1;
                        else
                        begin
                            // single operator goes out directly, then restart on c
                            out_v_next  = 1'b1;
                            o_cls_next  = CLS_OPER;
                            o_sub_next  = op_sub(opf_reg);
                            o_ch_next   = opf_reg;
                            o_len_next  = LEN_W'(1);
                            o_last_next = 1'b1;
                            pend_set    = 1'b1;
                            mode_next   = M_IDLE;
                            cnt_next    = '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            // Token start from idle
            if (start)
            begin
                if (is_space(c))
                begin
                end
                else if (is_alpha(c) || (c == C_UNDER))
                begin
                    mode_next = M_WORD;
                    app       = 1'b1;
                end
                else if (is_digit(c))
                begin
                    mode_next = M_INT;
                    app       = 1'b1;
                end
                else if (c == C_QUOTE)
                    mode_next = M_STR;
                else if ((c == C_LPAR) || (c == C_RPAR) || (c == C_COMMA) || (c == C_SEMI))
                begin
                    out_v_next  = 1'b1;
                    o_cls_next  = CLS_DELIM;
                    o_sub_next  = (c == C_LPAR)  ? SUB_DL_LPAR :
                                  (c == C_RPAR)  ? SUB_DL_RPAR :
                                  (c == C_COMMA) ? SUB_DL_COMMA : SUB_DL_SEMI;
                    o_ch_next   = c;
                    o_len_next  = LEN_W'(1);
                    o_last_next = 1'b1;
                end
                else if (is_opch(c))
                begin
                    mode_next = M_OP;
                    opf_next  = c;
                    app       = 1'b1;
                end
                else
                    err = 1'b1;
            end

            // Append: write at count, track keyword prefixes, check length
            if (app)
            begin
                wr_en    = 1'b1;
                cnt_next = cnt_inc;
                kwi_next = ((cnt_reg == '0) || kwi_reg) && (c == kw_char(KW_INT, 6'(cnt_reg)));
                kwc_next = ((cnt_reg == '0) || kwc_reg) && (c == kw_char(KW_CHAR, 6'(cnt_reg)));
                kwk_next = ((cnt_reg == '0) || kwk_reg) && (c == kw_char(KW_CONT, 6'(cnt_reg)));
                if (cnt_inc >= CNT_W'(MAX_LEXEME))
                    err = 1'b1;
            end

            // Error beat
            if (err)
            begin
                out_v_next  = 1'b1;
                o_cls_next  = CLS_ERROR;
                o_sub_next  = SUB_NONE;
                o_ch_next   = C_ZERO;
                o_len_next  = '0;
                o_last_next = 1'b1;
                mode_next   = M_ERR;
            end

            // Word class from keyword prefix flags
            if (emit_go && (mode_reg == M_WORD))
            begin
                if (kwi_reg && (6'(cnt_reg) == 6'd3))
                begin
                    em_cls_next = CLS_KEYWORD;
                    em_sub_next = SUB_KW_INT;
                end
                else if (kwc_reg && (6'(cnt_reg) == 6'd4))
                begin
                    em_cls_next = CLS_KEYWORD;
                    em_sub_next = SUB_KW_CHAR;
                end
                else if (kwk_reg && (6'(cnt_reg) == 6'd8))
                begin
                    em_cls_next = CLS_KEYWORD;
                    em_sub_next = SUB_KW_CONT;
                end
                else
                begin
                    em_cls_next = CLS_IDENT;
                    em_sub_next = SUB_NONE;
                end
            end

            // Drain setup: first read now, RAM holds data until next read
            if (emit_go)
            begin
                em_cnt_next = cnt_reg;
                em_idx_next = '0;
                rd_en       = 1'b1;
                rd_addr     = '0;
                ctl_next    = CTL_EMIT;
                mode_next   = M_IDLE;
                cnt_next    = '0;
            end
            else if (pend_set)
                ctl_next = CTL_START;
            else
                ctl_next = CTL_RUN;

            pend_v_next = pend_set;
            if (pend_set)
                pend_next = c;

            // End of text always returns to idle with an empty buffer
            if (eot)
            begin
                mode_next = M_IDLE;
                cnt_next  = '0;
            end
        end
        else if (ctl_reg == CTL_EMIT)
        begin
            // Drain lexeme one beat per cycle while out is not held
            if (out_free)
            begin
                out_v_next  = 1'b1;
                o_cls_next  = em_cls_reg;
                o_sub_next  = em_sub_reg;
                o_ch_next   = rd_data;
                o_len_next  = LEN_W'(em_cnt_reg);
                o_last_next = em_last;
                if (em_last)
                    ctl_next = pend_v_reg ? CTL_START : CTL_RUN;
                else
                begin
                    em_idx_next = em_idx_reg + AW'(1);
                    rd_en       = 1'b1;
                    rd_addr     = em_idx_reg + AW'(1);
                end
            end
        end
    end

    // State and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_IDLE;
            ctl_reg    <= CTL_RUN;
            cnt_reg    <= '0;
            kwi_reg    <= 1'b0;
            kwc_reg    <= 1'b0;
            kwk_reg    <= 1'b0;
            opf_reg    <= '0;
            pend_reg   <= '0;
            pend_v_reg <= 1'b0;
            em_cls_reg <= '0;
            em_sub_reg <= '0;
            em_cnt_reg <= '0;
            em_idx_reg <= '0;
            out_v_reg  <= 1'b0;
            o_cls_reg  <= '0;
            o_sub_reg  <= '0;
            o_ch_reg   <= '0;
            o_len_reg  <= '0;
            o_last_reg <= 1'b0;
        end
        else
        begin
            mode_reg   <= mode_next;
            ctl_reg    <= ctl_next;
            cnt_reg    <= cnt_next;
            kwi_reg    <= kwi_next;
            kwc_reg    <= kwc_next;
            kwk_reg    <= kwk_next;
            opf_reg    <= opf_next;
            pend_reg   <= pend_next;
            pend_v_reg <= pend_v_next;
            em_cls_reg <= em_cls_next;
            em_sub_reg <= em_sub_next;
            em_cnt_reg <= em_cnt_next;
            em_idx_reg <= em_idx_next;
            out_v_reg  <= out_v_next;
            o_cls_reg  <= o_cls_next;
            o_sub_reg  <= o_sub_next;
            o_ch_reg   <= o_ch_next;
            o_len_reg  <= o_len_next;
            o_last_reg <= o_last_next;
        end
    end

    assign out_valid = out_v_reg;
    assign tok_class = o_cls_reg;
    assign tok_sub   = o_sub_reg;
    assign lex_char  = o_ch_reg;
    assign lex_len   = o_len_reg;
    assign last_char = o_last_reg;

endmodule
